// ----- rtl/tes_pkg.sv -----
// shared constants and types for the timing error statistics block
// no dependencies
package tes_pkg;

   localparam int TIME_BITS_DEF  = 48;
   localparam int COUNT_BITS_DEF = 32;
   localparam int SUM_BITS       = 64;
   localparam int QUEUE_DEPTH    = 4;

   localparam logic [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};

   typedef enum logic [1:0] {
      OP_MARK   = 2'd0,
      OP_EDGE   = 2'd1,
      OP_REPORT = 2'd2
   } op_type;

   typedef enum logic {
      CMD_SAMPLE = 1'b0,
      CMD_REPORT = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE   = 3'b001,
      BK_DIVIDE = 3'b010,
      BK_OUTPUT = 3'b100
   } back_state_type;

endpackage

// ----- rtl/tes_queue.sv -----
// small command queue between the front and back parts
// depends on tes_pkg
module tes_queue #(
   parameter int WIDTH = 50
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   import tes_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             push, pop;

   assign in_ready  = fill_ff != CNT_W'(QUEUE_DEPTH);
   assign out_valid = fill_ff != '0;
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + CNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ----- rtl/tes_front.sv -----
// front part: takes request transfers, keeps the due time and arm flag,
// forms timing errors and report commands; depends on tes_pkg
module tes_front #(
   parameter int TIME_BITS = tes_pkg::TIME_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_tuser,
   input  logic [TIME_BITS-1:0] req_tdata,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output logic [TIME_BITS+1:0] cmd_data
);
   import tes_pkg::*;

   localparam int ERR_BITS = TIME_BITS + 1;

   op_type               op;
   logic                 accept;
   logic                 armed_ff, armed_in;
   logic [TIME_BITS-1:0] due_ff, due_in;
   logic [ERR_BITS-1:0]  err;
   cmd_type              kind;

   assign op         = op_type'(req_tuser);
   assign req_tready = cmd_ready;
   assign accept     = req_tvalid && req_tready;
   assign err        = {1'b0, req_tdata} - {1'b0, due_ff};

   always_comb begin
      armed_in  = armed_ff;
      due_in    = due_ff;
      cmd_valid = 1'b0;
      kind      = CMD_SAMPLE;
      case (op)
         OP_MARK: begin
            if (accept) begin
               armed_in = 1'b1;
               due_in   = req_tdata;
            end
         end
         OP_EDGE: begin
            cmd_valid = req_tvalid && armed_ff;
            if (accept) begin
               armed_in = 1'b0;
            end
         end
         OP_REPORT: begin
            cmd_valid = req_tvalid;
            kind      = CMD_REPORT;
         end
         default: begin
            cmd_valid = 1'b0;
         end
      endcase
   end

   assign cmd_data = {kind, err};

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff <= 1'b0;
      end else begin
         armed_ff <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      due_ff <= due_in;
   end

endmodule

// ----- rtl/tes_back.sv -----
// back part: accumulates count, saturating sum, min and max, divides for
// the mean and holds the response register; depends on tes_pkg
module tes_back #(
   parameter int TIME_BITS  = tes_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = tes_pkg::COUNT_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   output logic                 cmd_ready,
   input  logic [TIME_BITS+1:0] cmd_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic                 rsp_tuser,
   output logic [((COUNT_BITS+4*(TIME_BITS+1)+7)/8)*8-1:0] rsp_tdata
);
   import tes_pkg::*;

   localparam int ERR_BITS = TIME_BITS + 1;
   localparam int RAW_W    = COUNT_BITS + 4 * ERR_BITS;
   localparam int RSP_W    = ((RAW_W + 7) / 8) * 8;
   localparam int STEP_W   = $clog2(SUM_BITS);

   back_state_type        state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [SUM_BITS-1:0]   sum_ff, sum_in;
   logic [ERR_BITS-1:0]   low_ff, low_in, high_ff, high_in;
   logic [COUNT_BITS-1:0] div_ff, div_in;
   logic                  has_ff, has_in, neg_ff, neg_in;
   logic [ERR_BITS-1:0]   snap_low_ff, snap_low_in, snap_high_ff, snap_high_in;
   logic [SUM_BITS-1:0]   quo_ff, quo_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_has_ff, rsp_has_in;
   logic [RSP_W-1:0]      rsp_data_ff, rsp_data_in;

   cmd_type               kind;
   logic [ERR_BITS-1:0]   err;
   logic                  pop, load;
   logic [SUM_BITS:0]     sum_ext;
   logic [COUNT_BITS:0]   rem_sh;
   logic [COUNT_BITS+1:0] diff;
   logic [SUM_BITS-1:0]   quo_signed;
   logic [ERR_BITS-1:0]   spread;

   assign kind      = cmd_type'(cmd_data[ERR_BITS]);
   assign err       = cmd_data[ERR_BITS-1:0];
   assign cmd_ready = state_ff == BK_IDLE;
   assign pop       = cmd_valid && cmd_ready;
   assign load      = (state_ff == BK_OUTPUT) && (!rsp_valid_ff || rsp_tready);

   assign sum_ext = {sum_ff[SUM_BITS-1], sum_ff}
                  + {{(SUM_BITS+1-ERR_BITS){err[ERR_BITS-1]}}, err};
   assign rem_sh  = {rem_ff, quo_ff[SUM_BITS-1]};
   assign diff    = {1'b0, rem_sh} - {2'b00, div_ff};

   assign quo_signed = neg_ff ? -quo_ff : quo_ff;
   assign spread     = snap_high_ff - snap_low_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      div_in       = div_ff;
      has_in       = has_ff;
      neg_in       = neg_ff;
      snap_low_in  = snap_low_ff;
      snap_high_in = snap_high_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop && kind == CMD_SAMPLE && count_ff != '1) begin
               count_in = count_ff + COUNT_BITS'(1);
               if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
                  sum_in = sum_ext[SUM_BITS] ? SUM_MIN : SUM_MAX;
               end else begin
                  sum_in = sum_ext[SUM_BITS-1:0];
               end
               if (count_ff == '0 || $signed(err) < $signed(low_ff)) begin
                  low_in = err;
               end
               if (count_ff == '0 || $signed(err) > $signed(high_ff)) begin
                  high_in = err;
               end
            end else if (pop && kind == CMD_REPORT) begin
               div_in       = count_ff;
               has_in       = count_ff != '0;
               neg_in       = sum_ff[SUM_BITS-1];
               quo_in       = sum_ff[SUM_BITS-1] ? -sum_ff : sum_ff;
               rem_in       = '0;
               step_in      = '0;
               snap_low_in  = low_ff;
               snap_high_in = high_ff;
               count_in     = '0;
               sum_in       = '0;
               state_in     = (count_ff != '0) ? BK_DIVIDE : BK_OUTPUT;
            end
         end
         BK_DIVIDE: begin
            if (!diff[COUNT_BITS+1]) begin
               rem_in = diff[COUNT_BITS-1:0];
               quo_in = {quo_ff[SUM_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh[COUNT_BITS-1:0];
               quo_in = {quo_ff[SUM_BITS-2:0], 1'b0};
            end
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SUM_BITS - 1)) begin
               state_in = BK_OUTPUT;
            end
         end
         BK_OUTPUT: begin
            if (load) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_data_in  = rsp_data_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_has_in   = has_ff;
         if (has_ff) begin
            rsp_data_in = RSP_W'({spread, snap_high_ff, snap_low_ff,
                                  quo_signed[ERR_BITS-1:0], div_ff});
         end else begin
            rsp_data_in = '0;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      low_ff       <= low_in;
      high_ff      <= high_in;
      div_ff       <= div_in;
      has_ff       <= has_in;
      neg_ff       <= neg_in;
      snap_low_ff  <= snap_low_in;
      snap_high_ff <= snap_high_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_has_ff   <= rsp_has_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- rtl/timing_error_statistics.sv -----
// timing error statistics top level: front, command queue and back part
// depends on tes_pkg, tes_front, tes_queue and tes_back
//
// channel  direction  handshake               payload
// req      in         req_tvalid/req_tready   tuser op, tdata time_stamp
// rsp      out        rsp_tvalid/rsp_tready   tuser has_samples, tdata statistics
//
// a mark stays in the front; an armed edge is written into the queue, then accumulated when the back part takes it
// a report with samples runs 64 divide steps before the back part loads the response
// an empty report skips the divider and goes straight to loading the response
// a four-entry queue lets the front keep taking transfers while the back divides
// reset is synchronous and clears the arm flag, statistics, queue and response valid
// a stalled response is held in its register; the back part waits on it
module timing_error_statistics #(
   parameter int TIME_BITS  = tes_pkg::TIME_BITS_DEF,
   parameter int COUNT_BITS = tes_pkg::COUNT_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // op
   input  logic [1:0] req_tuser,
   // time_stamp
   input  logic [((TIME_BITS+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // has_samples
   output logic rsp_tuser,
   // sample_count, mean_error, min_error, max_error, error_spread
   output logic [((COUNT_BITS+4*(TIME_BITS+1)+7)/8)*8-1:0] rsp_tdata
);
   import tes_pkg::*;

   localparam int ERR_BITS = TIME_BITS + 1;
   localparam int CMD_W    = ERR_BITS + 1;

   logic             f_valid, f_ready;
   logic [CMD_W-1:0] f_data;
   logic             b_valid, b_ready;
   logic [CMD_W-1:0] b_data;

   tes_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata[TIME_BITS-1:0]),
      .cmd_valid  (f_valid),
      .cmd_ready  (f_ready),
      .cmd_data   (f_data)
   );

   tes_queue #(
      .WIDTH (CMD_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   (f_data),
      .out_valid (b_valid),
      .out_ready (b_ready),
      .out_data  (b_data)
   );

   tes_back #(
      .TIME_BITS  (TIME_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (b_valid),
      .cmd_ready  (b_ready),
      .cmd_data   (b_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef ASSERT_OFF
   localparam int MIN_LO = COUNT_BITS + 2 * ERR_BITS;
   localparam int MAX_LO = COUNT_BITS + 3 * ERR_BITS;
   localparam int SPR_LO = COUNT_BITS + 4 * ERR_BITS;

   logic [ERR_BITS-1:0] chk_min, chk_max, chk_spread;

   assign chk_min    = rsp_tdata[MIN_LO-1 -: ERR_BITS];
   assign chk_max    = rsp_tdata[MAX_LO-1 -: ERR_BITS];
   assign chk_spread = rsp_tdata[SPR_LO-1 -: ERR_BITS];

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("empty report carries non-zero statistics");

   a_count_set: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[COUNT_BITS-1:0] != '0)
      else $error("report with samples has zero count");

   a_spread: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         chk_spread == ERR_BITS'(chk_max - chk_min) &&
         $signed(chk_max) >= $signed(chk_min))
      else $error("spread does not match max minus min");

   a_front_drop: assert property (@(posedge clock) disable iff (reset)
      f_valid && !f_ready |-> !req_tready)
      else $error("request taken while queue full");
`endif

endmodule
